// ===== src/adaptive_replacement_cache_policy_assert.svh =====
// ---------------------------------------------------------------------------
// arc assertion macros
// concurrent assertion wrappers, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_REPLACEMENT_CACHE_POLICY_ASSERT_SVH
`define ADAPTIVE_REPLACEMENT_CACHE_POLICY_ASSERT_SVH
`ifndef SYNTHESIS
`define ARC_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error("arc assertion failed");
`define ARC_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("arc assertion failed");
`else
`define ARC_ASSERT(lbl, ck, rstn, prop)
`define ARC_ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`endif
`endif

// ===== src/arc_pkg.sv =====
// ---------------------------------------------------------------------------
// arc package
// sizes, list codes, cell commands and controller states
// ---------------------------------------------------------------------------
`default_nettype none
package arc_pkg;
	localparam int CAPACITY_MAX = 64;
	localparam int ID_BITS = 64;
	localparam int ID_FIELD_BITS = 64;
	localparam int DIR_SLOTS = 2 * CAPACITY_MAX;
	localparam int RANK_BITS = $clog2(DIR_SLOTS);
	localparam int CNT_BITS = $clog2(DIR_SLOTS + 1);
	localparam int CAP_BITS = $clog2(CAPACITY_MAX + 1);
	localparam int OUTCOME_BITS = 3;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam int DIV_STEP_BITS = $clog2(CNT_BITS + 1);
	localparam logic [ADDR_BITS-1:0] REG_CAPACITY_ADDR = '0;

	typedef enum logic [1:0] {LST_T1, LST_T2, LST_B1, LST_B2} list_t;

	typedef enum logic [OUTCOME_BITS-1:0] {
		OUT_MISS, OUT_HIT_T1, OUT_HIT_T2, OUT_GHOST_B1, OUT_GHOST_B2
	} outcome_t;

	typedef enum logic [2:0] {
		OP_NOP, OP_MATCH, OP_MARK_LRU, OP_MARK_FREE, OP_UNLINK, OP_PUSH, OP_DROP, OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		list_t                 lst;
		logic [RANK_BITS-1:0]  rnk;
		logic                  use_h;
	} cell_cmd_t;

	typedef struct packed {
		logic                  h_any;
		list_t                 h_list;
		logic [RANK_BITS-1:0]  h_rank;
		logic                  s_any;
	} row_stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MATCH, S_CLASS, S_DIV, S_ADJ, S_REPL, S_MVPUSH, S_HUNL,
		S_HPUSH, S_MISS, S_DROP, S_FREE, S_INS, S_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== src/arc_ifs.sv =====
// ---------------------------------------------------------------------------
// arc channel interfaces
// request and response channels with valid/ready transfer
// ---------------------------------------------------------------------------
`default_nettype none
interface arc_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [arc_pkg::ID_FIELD_BITS-1:0]    object_id;
	modport source(output valid, output object_id, input ready);
	modport sink(input valid, input object_id, output ready);
endinterface

interface arc_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 hit;
	logic [arc_pkg::OUTCOME_BITS-1:0]     outcome;
	logic [arc_pkg::CAP_BITS-1:0]         target_share;
	modport source(output valid, output hit, output outcome, output target_share, input ready);
	modport sink(input valid, input hit, input outcome, input target_share, output ready);
endinterface
`default_nettype wire

// ===== src/arc_cell.sv =====
// ---------------------------------------------------------------------------
// arc directory cell
// one directory slot: tag, list, rank and select flags
// ---------------------------------------------------------------------------
`default_nettype none
module arc_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire arc_pkg::cell_cmd_t            cmd,
	input  wire logic [arc_pkg::ID_BITS-1:0]   id,
	input  wire logic                          free_in,
	output logic                               free_out,
	output logic                               valid,
	output arc_pkg::list_t                     lst,
	output logic [arc_pkg::RANK_BITS-1:0]      rank,
	output logic                               hsel,
	output logic                               sel
);
	logic                          valid_q, hsel_q, sel_q;
	logic [arc_pkg::ID_BITS-1:0]   tag_q;
	arc_pkg::list_t                list_q;
	logic [arc_pkg::RANK_BITS-1:0] rank_q;
	logic                          tgt, claim;

	assign tgt      = cmd.use_h ? hsel_q : sel_q;
	assign claim    = !valid_q && !free_in;
	assign free_out = free_in | !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hsel_q  <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			case (cmd.op)
				arc_pkg::OP_MATCH: hsel_q <= valid_q && (tag_q == id);
				arc_pkg::OP_MARK_LRU: sel_q <= valid_q && (list_q == cmd.lst) && (rank_q == cmd.rnk);
				arc_pkg::OP_MARK_FREE: sel_q <= claim;
				arc_pkg::OP_PUSH: if (tgt) valid_q <= 1'b1;
				arc_pkg::OP_DROP: if (tgt) valid_q <= 1'b0;
				arc_pkg::OP_CLEAR: begin
					valid_q <= 1'b0;
					hsel_q  <= 1'b0;
					sel_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		case (cmd.op)
			arc_pkg::OP_MARK_FREE: if (claim) tag_q <= id;
			arc_pkg::OP_UNLINK: begin
				if (valid_q && !tgt && list_q == cmd.lst && rank_q > cmd.rnk)
					rank_q <= rank_q - 1'b1;
			end
			arc_pkg::OP_PUSH: begin
				if (tgt) begin
					list_q <= cmd.lst;
					rank_q <= '0;
				end else if (valid_q && list_q == cmd.lst) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign valid = valid_q;
	assign lst   = list_q;
	assign rank  = rank_q;
	assign hsel  = hsel_q;
	assign sel   = sel_q;
endmodule
`default_nettype wire

// ===== src/arc_row.sv =====
// ---------------------------------------------------------------------------
// arc cell row
// chain of directory cells with free-slot chain and status reduction
// ---------------------------------------------------------------------------
`default_nettype none
module arc_row (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire arc_pkg::cell_cmd_t            cmd,
	input  wire logic [arc_pkg::ID_BITS-1:0]   id,
	output arc_pkg::row_stat_t                 stat
);
	localparam int N = arc_pkg::DIR_SLOTS;

	logic [N:0]                    free_c;
	logic [N-1:0]                  valid_v, hsel_v, sel_v;
	arc_pkg::list_t                lst_v [N];
	logic [arc_pkg::RANK_BITS-1:0] rank_v [N];

	assign free_c[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		arc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.id       (id),
			.free_in  (free_c[i]),
			.free_out (free_c[i+1]),
			.valid    (valid_v[i]),
			.lst      (lst_v[i]),
			.rank     (rank_v[i]),
			.hsel     (hsel_v[i]),
			.sel      (sel_v[i])
		);
	end

	always_comb begin
		logic [1:0]                    hl;
		logic [arc_pkg::RANK_BITS-1:0] hr;
		hl = '0;
		hr = '0;
		for (int i = 0; i < N; i++) begin
			if (hsel_v[i] && valid_v[i]) begin
				hl = hl | lst_v[i];
				hr = hr | rank_v[i];
			end
		end
		stat.h_any  = |(hsel_v & valid_v);
		stat.h_list = arc_pkg::list_t'(hl);
		stat.h_rank = hr;
		stat.s_any  = |sel_v;
	end
endmodule
`default_nettype wire

// ===== src/arc_div.sv =====
// ---------------------------------------------------------------------------
// arc ratio divider
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module arc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [arc_pkg::CNT_BITS-1:0]  num,
	input  wire logic [arc_pkg::CNT_BITS-1:0]  den,
	output logic                               done,
	output logic [arc_pkg::CNT_BITS-1:0]       quot
);
	localparam int W = arc_pkg::CNT_BITS;

	logic                              busy_q, done_q;
	logic [arc_pkg::DIV_STEP_BITS-1:0] step_q;
	logic [W:0]                        rem_q, rem_sh;
	logic [W-1:0]                      quo_q, den_q;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == arc_pkg::DIV_STEP_BITS'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

// ===== src/adaptive_replacement_cache_policy.sv =====
// ---------------------------------------------------------------------------
// adaptive replacement cache policy
// arc list engine over a row of directory cells, one request at a time
// ---------------------------------------------------------------------------
// a t1/t2 hit runs match, classify, unlink and push to t2; a miss may also drop
//   and replace before the insert; a ghost hit may use the ratio divider first
// issue: a new request is taken only in idle, after the last response transfers,
//   since the command sequence is broadcast to the cell row
// reset: directory empty, all counts and target zero, capacity 64; no clear pass
`default_nettype none
module adaptive_replacement_cache_policy (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	arc_req_if.sink                              req,
	arc_rsp_if.source                            rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [arc_pkg::ADDR_BITS-1:0]   paddr,
	input  wire logic [arc_pkg::DATA_BITS-1:0]   pwdata,
	output logic [arc_pkg::DATA_BITS-1:0]        prdata,
	output logic                                 pready
);
	`include "adaptive_replacement_cache_policy_assert.svh"

	localparam int CW = arc_pkg::CNT_BITS;

	arc_pkg::state_t               state_q, state_d;
	logic [arc_pkg::ID_BITS-1:0]   id_q, id_d;
	logic                          hit_q, hit_d, found_q, found_d, fb2_q, fb2_d;
	logic                          ra_q, ra_d;
	arc_pkg::outcome_t             outcome_q, outcome_d;
	arc_pkg::list_t                hlist_q, hlist_d, mvf_q, mvf_d, mvt_q, mvt_d, dl_q, dl_d;
	logic [arc_pkg::CAP_BITS-1:0]  p_q, p_d, cap_q, cap_d, cap_wr;
	logic [CW-1:0]                 t1_q, t1_d, t2_q, t2_d, b1_q, b1_d, b2_q, b2_d;
	logic [CW-1:0]                 d_q, d_d, div_num, div_den, div_quot;
	logic                          div_start, div_done, cfg_wr;
	arc_pkg::cell_cmd_t            cmd;
	arc_pkg::row_stat_t            stat;
	logic [CW:0]                   l1, p_sum, resident;
	logic [CW+1:0]                 tot, cap_w;
	logic                          drop_need;

	function automatic logic [CW-1:0] cnt_of(arc_pkg::list_t l, logic [CW-1:0] a,
			logic [CW-1:0] b, logic [CW-1:0] c, logic [CW-1:0] d);
		case (l)
			arc_pkg::LST_T1: return a;
			arc_pkg::LST_T2: return b;
			arc_pkg::LST_B1: return c;
			default:         return d;
		endcase
	endfunction

	arc_row u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.id     (id_q),
		.stat   (stat)
	);

	arc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign cfg_wr = psel && penable && pwrite && pready && (paddr == arc_pkg::REG_CAPACITY_ADDR);
	assign pready = 1'b1;
	assign prdata = (paddr == arc_pkg::REG_CAPACITY_ADDR) ? arc_pkg::DATA_BITS'(cap_q) : '0;

	always_comb begin
		cap_wr = pwdata[arc_pkg::CAP_BITS-1:0];
		if (cap_wr == '0)
			cap_wr = arc_pkg::CAP_BITS'(1);
		else if (int'(cap_wr) > arc_pkg::CAPACITY_MAX)
			cap_wr = arc_pkg::CAP_BITS'(arc_pkg::CAPACITY_MAX);
	end

	assign div_num  = (stat.h_list == arc_pkg::LST_B1) ? b2_q : b1_q;
	assign div_den  = (stat.h_list == arc_pkg::LST_B1) ? b1_q : b2_q;
	assign l1       = {1'b0, t1_q} + {1'b0, b1_q};
	assign tot      = {1'b0, l1} + {2'b0, t2_q} + {2'b0, b2_q};
	assign cap_w    = (CW + 2)'(cap_q);
	assign p_sum    = (CW + 1)'(p_q) + {1'b0, d_q};
	assign resident = {1'b0, t1_q} + {1'b0, t2_q};

	assign req.ready        = (state_q == arc_pkg::S_IDLE);
	assign rsp.valid        = (state_q == arc_pkg::S_OUT);
	assign rsp.hit          = hit_q;
	assign rsp.outcome      = outcome_q;
	assign rsp.target_share = p_q;

	always_comb begin
		state_d   = state_q;
		id_d      = id_q;
		hit_d     = hit_q;
		found_d   = found_q;
		fb2_d     = fb2_q;
		ra_d      = ra_q;
		outcome_d = outcome_q;
		hlist_d   = hlist_q;
		mvf_d     = mvf_q;
		mvt_d     = mvt_q;
		dl_d      = dl_q;
		p_d       = p_q;
		cap_d     = cap_q;
		t1_d      = t1_q;
		t2_d      = t2_q;
		b1_d      = b1_q;
		b2_d      = b2_q;
		d_d       = d_q;
		div_start = 1'b0;
		drop_need = 1'b0;
		cmd       = '{op: arc_pkg::OP_NOP, lst: arc_pkg::LST_T1, rnk: '0, use_h: 1'b0};

		case (state_q)
			arc_pkg::S_IDLE: begin
				if (req.valid) begin
					id_d    = req.object_id[arc_pkg::ID_BITS-1:0];
					state_d = arc_pkg::S_MATCH;
				end
			end
			arc_pkg::S_MATCH: begin
				cmd.op  = arc_pkg::OP_MATCH;
				state_d = arc_pkg::S_CLASS;
			end
			arc_pkg::S_CLASS: begin
				found_d = stat.h_any;
				hlist_d = stat.h_list;
				hit_d   = 1'b0;
				fb2_d   = 1'b0;
				d_d     = CW'(1);
				if (!stat.h_any) begin
					outcome_d = arc_pkg::OUT_MISS;
					state_d   = arc_pkg::S_MISS;
				end else begin
					case (stat.h_list)
						arc_pkg::LST_T1: begin
							hit_d     = 1'b1;
							outcome_d = arc_pkg::OUT_HIT_T1;
							state_d   = arc_pkg::S_HUNL;
						end
						arc_pkg::LST_T2: begin
							hit_d     = 1'b1;
							outcome_d = arc_pkg::OUT_HIT_T2;
							state_d   = arc_pkg::S_HUNL;
						end
						arc_pkg::LST_B1: begin
							outcome_d = arc_pkg::OUT_GHOST_B1;
							if (b1_q >= b2_q || b1_q == '0) begin
								state_d = arc_pkg::S_ADJ;
							end else begin
								div_start = 1'b1;
								state_d   = arc_pkg::S_DIV;
							end
						end
						default: begin
							outcome_d = arc_pkg::OUT_GHOST_B2;
							fb2_d     = 1'b1;
							if (b2_q >= b1_q || b2_q == '0) begin
								state_d = arc_pkg::S_ADJ;
							end else begin
								div_start = 1'b1;
								state_d   = arc_pkg::S_DIV;
							end
						end
					endcase
				end
			end
			arc_pkg::S_DIV: begin
				if (div_done) begin
					d_d     = div_quot;
					state_d = arc_pkg::S_ADJ;
				end
			end
			arc_pkg::S_ADJ: begin
				if (!fb2_q)
					p_d = (p_sum > (CW + 1)'(cap_q)) ? cap_q : arc_pkg::CAP_BITS'(p_sum);
				else
					p_d = (CW'(p_q) > d_q) ? arc_pkg::CAP_BITS'(CW'(p_q) - d_q) : '0;
				state_d = arc_pkg::S_REPL;
			end
			arc_pkg::S_REPL: begin
				state_d = found_q ? arc_pkg::S_HUNL : arc_pkg::S_FREE;
				if (t1_q != '0 && (t1_q > CW'(p_q) || (fb2_q && t1_q == CW'(p_q)))) begin
					mvf_d = arc_pkg::LST_T1;
					mvt_d = arc_pkg::LST_B1;
					state_d = arc_pkg::S_MVPUSH;
				end else if (t2_q != '0) begin
					mvf_d = arc_pkg::LST_T2;
					mvt_d = arc_pkg::LST_B2;
					state_d = arc_pkg::S_MVPUSH;
				end else if (t1_q != '0) begin
					mvf_d = arc_pkg::LST_T1;
					mvt_d = arc_pkg::LST_B1;
					state_d = arc_pkg::S_MVPUSH;
				end
				if (state_d == arc_pkg::S_MVPUSH) begin
					cmd.op  = arc_pkg::OP_MARK_LRU;
					cmd.lst = mvf_d;
					cmd.rnk = arc_pkg::RANK_BITS'(cnt_of(mvf_d, t1_q, t2_q, b1_q, b2_q) - 1'b1);
				end
			end
			arc_pkg::S_MVPUSH: begin
				cmd.op  = arc_pkg::OP_PUSH;
				cmd.lst = mvt_q;
				case (mvf_q)
					arc_pkg::LST_T1: t1_d = t1_q - 1'b1;
					default:         t2_d = t2_q - 1'b1;
				endcase
				case (mvt_q)
					arc_pkg::LST_B1: b1_d = b1_q + 1'b1;
					default:         b2_d = b2_q + 1'b1;
				endcase
				state_d = found_q ? arc_pkg::S_HUNL : arc_pkg::S_FREE;
			end
			arc_pkg::S_HUNL: begin
				cmd.op    = arc_pkg::OP_UNLINK;
				cmd.lst   = hlist_q;
				cmd.rnk   = stat.h_rank;
				cmd.use_h = 1'b1;
				case (hlist_q)
					arc_pkg::LST_T1: t1_d = t1_q - 1'b1;
					arc_pkg::LST_T2: t2_d = t2_q - 1'b1;
					arc_pkg::LST_B1: b1_d = b1_q - 1'b1;
					default:         b2_d = b2_q - 1'b1;
				endcase
				state_d = arc_pkg::S_HPUSH;
			end
			arc_pkg::S_HPUSH: begin
				cmd.op    = arc_pkg::OP_PUSH;
				cmd.lst   = arc_pkg::LST_T2;
				cmd.use_h = 1'b1;
				t2_d      = t2_q + 1'b1;
				state_d   = arc_pkg::S_OUT;
			end
			arc_pkg::S_MISS: begin
				ra_d = 1'b0;
				dl_d = arc_pkg::LST_B2;
				if ({1'b0, l1} == cap_w) begin
					drop_need = 1'b1;
					if ((CW + 2)'(t1_q) < cap_w) begin
						dl_d = arc_pkg::LST_B1;
						ra_d = 1'b1;
					end else begin
						dl_d = arc_pkg::LST_T1;
					end
				end else if ({1'b0, l1} < cap_w && tot >= cap_w) begin
					ra_d      = 1'b1;
					drop_need = (tot == {cap_w[CW:0], 1'b0});
				end
				if (drop_need && cnt_of(dl_d, t1_q, t2_q, b1_q, b2_q) != '0) begin
					cmd.op  = arc_pkg::OP_MARK_LRU;
					cmd.lst = dl_d;
					cmd.rnk = arc_pkg::RANK_BITS'(cnt_of(dl_d, t1_q, t2_q, b1_q, b2_q) - 1'b1);
					state_d = arc_pkg::S_DROP;
				end else begin
					state_d = ra_d ? arc_pkg::S_REPL : arc_pkg::S_FREE;
				end
			end
			arc_pkg::S_DROP: begin
				cmd.op = arc_pkg::OP_DROP;
				case (dl_q)
					arc_pkg::LST_T1: t1_d = t1_q - 1'b1;
					arc_pkg::LST_T2: t2_d = t2_q - 1'b1;
					arc_pkg::LST_B1: b1_d = b1_q - 1'b1;
					default:         b2_d = b2_q - 1'b1;
				endcase
				state_d = ra_q ? arc_pkg::S_REPL : arc_pkg::S_FREE;
			end
			arc_pkg::S_FREE: begin
				cmd.op  = arc_pkg::OP_MARK_FREE;
				state_d = arc_pkg::S_INS;
			end
			arc_pkg::S_INS: begin
				if (stat.s_any) begin
					cmd.op  = arc_pkg::OP_PUSH;
					cmd.lst = arc_pkg::LST_T1;
					t1_d    = t1_q + 1'b1;
				end
				state_d = arc_pkg::S_OUT;
			end
			arc_pkg::S_OUT: begin
				if (rsp.ready)
					state_d = arc_pkg::S_IDLE;
			end
			default: state_d = arc_pkg::S_IDLE;
		endcase

		// capacity write empties the directory
		if (cfg_wr) begin
			cmd.op = arc_pkg::OP_CLEAR;
			cap_d  = cap_wr;
			p_d    = '0;
			t1_d   = '0;
			t2_d   = '0;
			b1_d   = '0;
			b2_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arc_pkg::S_IDLE;
			cap_q   <= arc_pkg::CAP_BITS'(arc_pkg::CAPACITY_MAX);
			p_q     <= '0;
			t1_q    <= '0;
			t2_q    <= '0;
			b1_q    <= '0;
			b2_q    <= '0;
			found_q <= 1'b0;
			fb2_q   <= 1'b0;
			ra_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cap_q   <= cap_d;
			p_q     <= p_d;
			t1_q    <= t1_d;
			t2_q    <= t2_d;
			b1_q    <= b1_d;
			b2_q    <= b2_d;
			found_q <= found_d;
			fb2_q   <= fb2_d;
			ra_q    <= ra_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q      <= id_d;
		hit_q     <= hit_d;
		outcome_q <= outcome_d;
		hlist_q   <= hlist_d;
		mvf_q     <= mvf_d;
		mvt_q     <= mvt_d;
		dl_q      <= dl_d;
		d_q       <= d_d;
	end

	`ARC_ASSERT(a_share_le_cap, clk, arst_n, p_q <= cap_q)
	`ARC_ASSERT_IMPL(a_idle_resident, clk, arst_n, state_q == arc_pkg::S_IDLE, resident <= (CW + 1)'(cap_q))
	`ARC_ASSERT_IMPL(a_hit_code, clk, arst_n, rsp.valid, rsp.hit == (outcome_q == arc_pkg::OUT_HIT_T1 || outcome_q == arc_pkg::OUT_HIT_T2))
endmodule
`default_nettype wire

// ===== tb/adaptive_replacement_cache_policy_tb.sv =====
// ---------------------------------------------------------------------------
// adaptive replacement cache policy testbench
// drives request streams over several capacities through the request channel,
// predicts each arc outcome and target share, and checks every response
// ---------------------------------------------------------------------------
`default_nettype none
module adaptive_replacement_cache_policy_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                              hit;
		arc_pkg::outcome_t                 outcome;
		logic [arc_pkg::CAP_BITS-1:0]      share;
	} arc_result_t;

	typedef struct {
		int                                cap_write;
		logic [arc_pkg::ID_FIELD_BITS-1:0] id;
		bit                                typed;
		arc_result_t                       res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [arc_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [arc_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [arc_pkg::DATA_BITS-1:0] prdata;
	logic pready;

	arc_req_if req();
	arc_rsp_if rsp();

	adaptive_replacement_cache_policy u_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// arc directory mirror
	logic [arc_pkg::ID_FIELD_BITS-1:0] dir_tag [arc_pkg::DIR_SLOTS];
	bit                                dir_vld [arc_pkg::DIR_SLOTS];
	arc_pkg::list_t                    dir_lst [arc_pkg::DIR_SLOTS];
	int                                dir_rnk [arc_pkg::DIR_SLOTS];
	int                                list_cnt [4];
	int                                share_p;
	int                                cap_c;

	arc_result_t              pending_results[$];
	arc_result_t              typed_results[int];
	int                       n_accepted = 0;
	int                       errors = 0;
	bit                       quiet = 1'b0;

	function automatic void dir_clear();
		for (int i = 0; i < arc_pkg::DIR_SLOTS; i++) begin
			dir_vld[i] = 1'b0;
		end
		for (int i = 0; i < 4; i++) begin
			list_cnt[i] = 0;
		end
		share_p = 0;
	endfunction

	function automatic void list_unlink(int s);
		arc_pkg::list_t l;
		l = dir_lst[s];
		for (int i = 0; i < arc_pkg::DIR_SLOTS; i++) begin
			if (dir_vld[i] && i != s && dir_lst[i] == l && dir_rnk[i] > dir_rnk[s])
				dir_rnk[i]--;
		end
		if (list_cnt[l] > 0)
			list_cnt[l]--;
	endfunction

	function automatic void list_push(int s, arc_pkg::list_t l);
		for (int i = 0; i < arc_pkg::DIR_SLOTS; i++) begin
			if (dir_vld[i] && i != s && dir_lst[i] == l)
				dir_rnk[i]++;
		end
		dir_vld[s] = 1'b1;
		dir_lst[s] = l;
		dir_rnk[s] = 0;
		list_cnt[l]++;
	endfunction

	function automatic int lru_slot(arc_pkg::list_t l);
		int best;
		best = -1;
		for (int i = 0; i < arc_pkg::DIR_SLOTS; i++) begin
			if (dir_vld[i] && dir_lst[i] == l && (best < 0 || dir_rnk[i] > dir_rnk[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic void demote_lru(arc_pkg::list_t from, arc_pkg::list_t to);
		int s;
		s = lru_slot(from);
		if (s >= 0) begin
			list_unlink(s);
			list_push(s, to);
		end
	endfunction

	function automatic void discard_lru(arc_pkg::list_t l);
		int s;
		s = lru_slot(l);
		if (s >= 0) begin
			list_unlink(s);
			dir_vld[s] = 1'b0;
		end
	endfunction

	function automatic void arc_evict(bit from_b2);
		int t1;
		t1 = list_cnt[arc_pkg::LST_T1];
		if (t1 > 0 && (t1 > share_p || (from_b2 && t1 == share_p)))
			demote_lru(arc_pkg::LST_T1, arc_pkg::LST_B1);
		else if (list_cnt[arc_pkg::LST_T2] > 0)
			demote_lru(arc_pkg::LST_T2, arc_pkg::LST_B2);
		else if (t1 > 0)
			demote_lru(arc_pkg::LST_T1, arc_pkg::LST_B1);
	endfunction

	function automatic arc_result_t arc_lookup(logic [arc_pkg::ID_FIELD_BITS-1:0] id);
		arc_result_t r;
		int s, d, l1, tot, b1, b2;
		s = -1;
		r.hit = 1'b0;
		r.outcome = arc_pkg::OUT_MISS;
		b1 = list_cnt[arc_pkg::LST_B1];
		b2 = list_cnt[arc_pkg::LST_B2];
		for (int i = 0; i < arc_pkg::DIR_SLOTS; i++) begin
			if (s < 0 && dir_vld[i] && dir_tag[i] == id)
				s = i;
		end
		if (s >= 0 && (dir_lst[s] == arc_pkg::LST_T1 || dir_lst[s] == arc_pkg::LST_T2)) begin
			r.hit = 1'b1;
			r.outcome = (dir_lst[s] == arc_pkg::LST_T1) ? arc_pkg::OUT_HIT_T1
				: arc_pkg::OUT_HIT_T2;
			list_unlink(s);
			list_push(s, arc_pkg::LST_T2);
		end else if (s >= 0 && dir_lst[s] == arc_pkg::LST_B1) begin
			d = (b1 >= b2 || b1 == 0) ? 1 : b2 / b1;
			r.outcome = arc_pkg::OUT_GHOST_B1;
			share_p = (share_p + d > cap_c) ? cap_c : share_p + d;
			arc_evict(1'b0);
			list_unlink(s);
			list_push(s, arc_pkg::LST_T2);
		end else if (s >= 0) begin
			d = (b2 >= b1 || b2 == 0) ? 1 : b1 / b2;
			r.outcome = arc_pkg::OUT_GHOST_B2;
			share_p = (share_p > d) ? share_p - d : 0;
			arc_evict(1'b1);
			list_unlink(s);
			list_push(s, arc_pkg::LST_T2);
		end else begin
			l1 = list_cnt[arc_pkg::LST_T1] + b1;
			if (l1 == cap_c) begin
				if (list_cnt[arc_pkg::LST_T1] < cap_c) begin
					discard_lru(arc_pkg::LST_B1);
					arc_evict(1'b0);
				end else begin
					discard_lru(arc_pkg::LST_T1);
				end
			end else if (l1 < cap_c) begin
				tot = l1 + list_cnt[arc_pkg::LST_T2] + list_cnt[arc_pkg::LST_B2];
				if (tot >= cap_c) begin
					if (tot == 2 * cap_c)
						discard_lru(arc_pkg::LST_B2);
					arc_evict(1'b0);
				end
			end
			s = -1;
			for (int i = 0; i < arc_pkg::DIR_SLOTS; i++) begin
				if (s < 0 && !dir_vld[i])
					s = i;
			end
			if (s >= 0) begin
				dir_tag[s] = id;
				list_push(s, arc_pkg::LST_T1);
			end
		end
		r.share = share_p[arc_pkg::CAP_BITS-1:0];
		return r;
	endfunction

	// response check, then prediction of the request accepted at this edge
	always @(posedge clk) begin
		arc_result_t e, p;
		if (rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response hit=%0b outcome=%0d share=%0d", $time,
					rsp.hit, rsp.outcome, rsp.target_share);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (rsp.hit !== e.hit || rsp.outcome !== e.outcome ||
						rsp.target_share !== e.share) begin
					$display("%0t: mismatch expected hit=%0b outcome=%0d share=%0d,",
						$time, e.hit, e.outcome, e.share,
						" actual hit=%0b outcome=%0d share=%0d",
						rsp.hit, rsp.outcome, rsp.target_share);
					errors++;
				end
			end
		end
		if (req.valid && req.ready) begin
			p = arc_lookup(req.object_id);
			if (typed_results.exists(n_accepted))
				p = typed_results[n_accepted];
			pending_results.push_back(p);
			n_accepted++;
		end
	end

	// response stalls
	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	task automatic send_request(logic [arc_pkg::ID_FIELD_BITS-1:0] id);
		req.valid <= 1'b1;
		req.object_id <= id;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_capacity(int value);
		int v;
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= arc_pkg::REG_CAPACITY_ADDR;
		pwdata <= arc_pkg::DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		v = value & 'h7f;
		if (v < 1) v = 1;
		if (v > arc_pkg::CAPACITY_MAX) v = arc_pkg::CAPACITY_MAX;
		cap_c = v;
		dir_clear();
	endtask

	function automatic arc_result_t mk(logic h, arc_pkg::outcome_t o, int p);
		arc_result_t r;
		r.hit = h;
		r.outcome = o;
		r.share = p[arc_pkg::CAP_BITS-1:0];
		return r;
	endfunction

	stim_row_t directed[$];
	arc_result_t no_res;

	task automatic add_row(int cw, logic [arc_pkg::ID_FIELD_BITS-1:0] id, bit typed,
			arc_result_t r);
		stim_row_t row;
		row.cap_write = cw;
		row.id = id;
		row.typed = typed;
		row.res = r;
		directed.push_back(row);
	endtask

	initial begin
		int caps[$];
		logic [arc_pkg::ID_FIELD_BITS-1:0] base;
		int pool;
		req.valid = 1'b0;
		req.object_id = '0;
		cap_c = 64;
		dir_clear();
		no_res = mk(1'b0, arc_pkg::OUT_MISS, 0);

		add_row(-1, '0, 1, mk(1'b0, arc_pkg::OUT_MISS, 0));
		add_row(-1, '0, 1, mk(1'b1, arc_pkg::OUT_HIT_T1, 0));
		add_row(-1, '0, 1, mk(1'b1, arc_pkg::OUT_HIT_T2, 0));
		add_row(-1, '1, 1, mk(1'b0, arc_pkg::OUT_MISS, 0));
		add_row(-1, '1, 1, mk(1'b1, arc_pkg::OUT_HIT_T1, 0));
		// zero capacity clamps to one
		add_row(0, 64'h5, 0, no_res);
		add_row(-1, 64'h6, 0, no_res);
		add_row(-1, 64'h5, 0, no_res);
		add_row(-1, 64'h6, 0, no_res);
		// oversize capacity clamps to the maximum
		add_row(127, 64'h1, 0, no_res);
		add_row(-1, 64'h1, 0, no_res);
		// ghost hits and replace fallback at capacity two
		add_row(2, 64'hA, 0, no_res);
		add_row(-1, 64'hA, 0, no_res);
		add_row(-1, 64'hB, 0, no_res);
		add_row(-1, 64'hC, 0, no_res);
		add_row(-1, 64'hB, 0, no_res);
		add_row(-1, 64'hD, 0, no_res);
		add_row(-1, 64'hA, 0, no_res);
		add_row(-1, 64'hC, 0, no_res);
		add_row(-1, 64'hE, 0, no_res);
		add_row(-1, 64'hB, 0, no_res);
		add_row(-1, 64'hA, 0, no_res);
		add_row(-1, 64'hD, 0, no_res);
		add_row(-1, 64'hF, 0, no_res);

		// each directed row sends exactly one request, so the row index is its transfer index
		foreach (directed[i]) begin
			if (directed[i].typed)
				typed_results[i] = directed[i].res;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].cap_write >= 0)
				write_capacity(directed[i].cap_write);
			send_request(directed[i].id);
		end

		caps = '{1, 64, 3, 8, 2, 16, 5, 64};
		foreach (caps[k]) begin
			write_capacity((k == 5) ? $urandom_range(1, 64) : caps[k]);
			base = {$urandom, $urandom};
			pool = 3 * cap_c + 2;
			if (pool > 40) pool = 40;
			for (int n = 0; n < 68; n++) begin
				if (k == caps.size() - 1 && n >= 8)
					quiet = 1'b1;
				if (k == 2 && n == 30)
					drain();
				if ($urandom_range(0, 15) == 0)
					send_request({$urandom, $urandom});
				else
					send_request(base ^ arc_pkg::ID_FIELD_BITS'($urandom_range(0, pool - 1)));
			end
		end

		drain();
		if (errors == 0)
			$display("adaptive_replacement_cache_policy regression: pass");
		else
			$display("adaptive_replacement_cache_policy regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("adaptive_replacement_cache_policy regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/arc_pkg.sv
src/arc_ifs.sv
src/arc_cell.sv
src/arc_row.sv
src/arc_div.sv
src/adaptive_replacement_cache_policy.sv
tb/adaptive_replacement_cache_policy_tb.sv
